FILE: rtl/btsd_pkg.sv
// Shared types and constants for the button tuned square drive block.
// No dependencies; every other rtl file but btsd_if imports this package.
package btsd_pkg;

    localparam int unsigned START_HALF_PERIOD_DEF = 150;

    localparam int PERIOD_W = 16;
    localparam int STEP_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT = 2'd2;

    localparam logic [STEP_W-1:0]   STEP_SIZE_RST   = 8'd5;
    localparam logic [PERIOD_W-1:0] LOWER_LIMIT_RST = 16'd25;
    localparam logic [PERIOD_W-1:0] UPPER_LIMIT_RST = 16'd65531;
    localparam logic [PERIOD_W-1:0] PERIOD_MIN      = 16'd1;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX      = 16'hFFFF;

    typedef enum logic [1:0] {
        BTN_RELEASED     = 2'd0,
        BTN_PRESS_PEND   = 2'd1,
        BTN_PRESSED      = 2'd2,
        BTN_RELEASE_PEND = 2'd3
    } t_btn_state;

    typedef struct packed {
        logic press;    // confirmed press on this scan
        logic release_; // confirmed release on this scan
    } t_btn_evt;

    typedef struct packed {
        logic [STEP_W-1:0]   step_size;
        logic [PERIOD_W-1:0] lower_limit;
        logic [PERIOD_W-1:0] upper_limit;
    } t_cfg;

endpackage

FILE: rtl/btsd_if.sv
// Valid/ready channel interfaces for the input tick beat and the result beat.
// Depends on nothing but plain logic types.
interface btsd_in_if;
    logic valid;
    logic ready;
    logic scan_now;
    logic plus_pin;
    logic minus_pin;

    modport source (output valid, scan_now, plus_pin, minus_pin, input ready);
    modport sink   (input valid, scan_now, plus_pin, minus_pin, output ready);
endinterface

interface btsd_out_if;
    logic        valid;
    logic        ready;
    logic        drive_a;
    logic        drive_b;
    logic        led_lit;
    logic [15:0] current_period;

    modport source (output valid, drive_a, drive_b, led_lit, current_period, input ready);
    modport sink   (input valid, drive_a, drive_b, led_lit, current_period, output ready);
endinterface

FILE: rtl/btsd_debounce.sv
// Four-state button debounce: two equal samples in a row confirm a change.
// Depends on btsd_pkg for the state enum and event struct.
module btsd_debounce
    import btsd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_scan,
    input  logic     i_level,
    output t_btn_evt o_evt
);

    t_btn_state r_state;
    t_btn_state n_state;

    always_comb begin
        n_state       = r_state;
        o_evt.press   = 1'b0;
        o_evt.release_ = 1'b0;
        if (!i_level) begin
            case (r_state)
                BTN_RELEASED:     n_state = BTN_PRESS_PEND;
                BTN_RELEASE_PEND: n_state = BTN_PRESSED;
                BTN_PRESS_PEND: begin
                    n_state     = BTN_PRESSED;
                    o_evt.press = i_scan;
                end
                default:          n_state = r_state;
            endcase
        end else begin
            case (r_state)
                BTN_PRESSED:      n_state = BTN_RELEASE_PEND;
                BTN_PRESS_PEND:   n_state = BTN_RELEASED;
                BTN_RELEASE_PEND: begin
                    n_state        = BTN_RELEASED;
                    o_evt.release_ = i_scan;
                end
                default:          n_state = r_state;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BTN_RELEASED;
        end else if (i_scan) begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/btsd_period.sv
// Half period adjust: plus press shortens, minus press lengthens, saturating.
// Depends on btsd_pkg for widths, limits and the config struct.
module btsd_period
    import btsd_pkg::*;
(
    input  t_cfg                i_cfg,
    input  logic [PERIOD_W-1:0] i_half_period,
    input  logic                i_plus_press,
    input  logic                i_minus_press,
    output logic [PERIOD_W-1:0] o_half_period
);

    logic [PERIOD_W-1:0] step_ext;
    logic                plus_act;
    logic [PERIOD_W-1:0] after_plus;
    logic [PERIOD_W:0]   sum;

    assign step_ext   = {{(PERIOD_W-STEP_W){1'b0}}, i_cfg.step_size};
    assign plus_act   = i_plus_press && (i_half_period > i_cfg.lower_limit);
    assign after_plus = !plus_act ? i_half_period
                      : (i_half_period > step_ext) ? (i_half_period - step_ext)
                                                   : PERIOD_MIN;
    assign sum        = {1'b0, after_plus} + {1'b0, step_ext};

    always_comb begin
        o_half_period = after_plus;
        if (i_minus_press && (after_plus < i_cfg.upper_limit)) begin
            o_half_period = sum[PERIOD_W] ? PERIOD_MAX : sum[PERIOD_W-1:0];
        end
    end

endmodule

FILE: rtl/btsd_timer.sv
// Half period tick counter and drive phase; reloads the active period on wrap.
// Depends on btsd_pkg for widths.
module btsd_timer
    import btsd_pkg::*;
#(
    parameter int unsigned START_HALF_PERIOD = START_HALF_PERIOD_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic [PERIOD_W-1:0] i_half_period,
    output logic                o_phase
);

    logic [PERIOD_W-1:0] r_tick;
    logic [PERIOD_W-1:0] r_active;
    logic                r_phase;
    logic [PERIOD_W-1:0] cnt_inc;
    logic [PERIOD_W-1:0] limit;
    logic                wrap;

    assign limit   = (r_active == '0) ? PERIOD_MIN : r_active;
    assign cnt_inc = r_tick + PERIOD_W'(1);
    assign wrap    = (cnt_inc >= limit) || (cnt_inc == '0);
    assign o_phase = r_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick   <= '0;
            r_active <= PERIOD_W'(START_HALF_PERIOD);
            r_phase  <= 1'b1;
        end else if (i_adv) begin
            if (wrap) begin
                r_tick   <= '0;
                r_active <= i_half_period;
                r_phase  <= ~r_phase;
            end else begin
                r_tick   <= cnt_inc;
            end
        end
    end

endmodule

FILE: rtl/button_tuned_square_drive_core.sv
// Top level of the button tuned square drive block: config registers, period
// and LED state, result register. Depends on btsd_pkg, btsd_if, btsd_debounce,
// btsd_period and btsd_timer.
//
//   channel   dir  handshake        payload
//   i_item    in   valid / ready    scan_now, plus_pin, minus_pin
//   o_result  out  valid / ready    drive_a, drive_b, led_lit, current_period
//   i_cfg_*   in   write enable     index (2 bits), data (16 bits)
//
// Each accepted tick beat updates all non-config state at the accept edge
// and its result beat is valid the next cycle: one beat per cycle unless the
// result stalls. The limit is the single result register, which drains in
// the same cycle it refills. Reset (i_rst_n low, synchronous) restores start
// period, phase high, buttons released, LED lit, config defaults. A stalled
// result holds non-config state, and i_item.ready drops until it is taken.
module button_tuned_square_drive_core
    import btsd_pkg::*;
#(
    parameter int unsigned START_HALF_PERIOD = START_HALF_PERIOD_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    btsd_in_if.sink               i_item,
    btsd_out_if.source            o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg                r_cfg;
    logic [PERIOD_W-1:0] r_half_period;
    logic [PERIOD_W-1:0] n_half_period;
    logic                r_led;
    logic                n_led;
    logic                r_out_valid;
    logic                accept;
    logic                scan;
    logic                phase;
    t_btn_evt            plus_evt;
    t_btn_evt            minus_evt;

    // Take a new beat whenever the result slot is empty or draining now.
    assign i_item.ready = !r_out_valid || o_result.ready;
    assign accept       = i_item.valid && i_item.ready;
    assign scan         = accept && i_item.scan_now;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_size   <= STEP_SIZE_RST;
            r_cfg.lower_limit <= LOWER_LIMIT_RST;
            r_cfg.upper_limit <= UPPER_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STEP_SIZE:   r_cfg.step_size   <= i_cfg_data[STEP_W-1:0];
                CFG_LOWER_LIMIT: r_cfg.lower_limit <= i_cfg_data;
                CFG_UPPER_LIMIT: r_cfg.upper_limit <= i_cfg_data;
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    // Timer advances with the period selected before this beat's buttons.
    btsd_timer #(
        .START_HALF_PERIOD(START_HALF_PERIOD)
    ) u_timer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (accept),
        .i_half_period(r_half_period),
        .o_phase      (phase)
    );

    btsd_debounce u_plus (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_scan (scan),
        .i_level(i_item.plus_pin),
        .o_evt  (plus_evt)
    );

    btsd_debounce u_minus (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_scan (scan),
        .i_level(i_item.minus_pin),
        .o_evt  (minus_evt)
    );

    // Plus is applied first, then minus on the adjusted value.
    btsd_period u_period (
        .i_cfg        (r_cfg),
        .i_half_period(r_half_period),
        .i_plus_press (plus_evt.press),
        .i_minus_press(minus_evt.press),
        .o_half_period(n_half_period)
    );

    // LED follows the last confirmed event in scan order: minus wins.
    always_comb begin
        n_led = r_led;
        if (plus_evt.press) begin
            n_led = 1'b0;
        end else if (plus_evt.release_) begin
            n_led = 1'b1;
        end
        if (minus_evt.press) begin
            n_led = 1'b0;
        end else if (minus_evt.release_) begin
            n_led = 1'b1;
        end
    end

    // State registers double as the result payload: they only move on accept,
    // which only happens when the result slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= PERIOD_W'(START_HALF_PERIOD);
            r_led         <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_half_period <= n_half_period;
                r_led         <= n_led;
                r_out_valid   <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.drive_a        = phase;
    assign o_result.drive_b        = ~phase;
    assign o_result.led_lit        = r_led;
    assign o_result.current_period = r_half_period;

endmodule
